[rtl/core/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiply block
// Field widths, configuration register indexes and the control bundle
// that drives the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Payload widths
  localparam int ELEM_W = 16;   // Q8.8 input element
  localparam int PROD_W = 32;   // Q16.16 single product
  localparam int SUM_W  = 35;   // Q19.16 dot-product sum
  localparam int IDX_W  = 3;    // row and column index of a result

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // Control bundle from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;          // zero the accumulator
    logic operand_valid;  // operands on a_data and b_data are live
  } mac_ctrl_t;

endpackage

[rtl/core/mm_feed_if.sv]
// ----------------------------------------------------------------------------
// mm_feed_if: input element channel
// Carries one Q8.8 matrix element per transfer.
// ----------------------------------------------------------------------------
interface mm_feed_if;
  logic                              valid;
  logic                              ready;
  logic signed [mm_pkg::ELEM_W-1:0]  element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

[rtl/core/mm_result_if.sv]
// ----------------------------------------------------------------------------
// mm_result_if: product element channel
// Carries one element of the product with its position and a last flag.
// ----------------------------------------------------------------------------
interface mm_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [mm_pkg::SUM_W-1:0]  product_value;
  logic [mm_pkg::IDX_W-1:0]         row_index;
  logic [mm_pkg::IDX_W-1:0]         col_index;
  logic                             last_result;

  modport source (output valid, output product_value, output row_index,
                  output col_index, output last_result, input ready);
  modport sink   (input valid, input product_value, input row_index,
                  input col_index, input last_result, output ready);
endinterface

[rtl/core/mm_cfg_if.sv]
// ----------------------------------------------------------------------------
// mm_cfg_if: configuration write channel
// Carries a register index and the data to write there.
// ----------------------------------------------------------------------------
interface mm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mm_pkg::CFG_ADDR_W-1:0]    index;
  logic [mm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/mm_mac.sv]
// ----------------------------------------------------------------------------
// mm_mac: shared multiply-accumulate unit
// Registers one 16x16 signed product per cycle and adds it into a
// 35-bit accumulator that wraps on overflow.
// ----------------------------------------------------------------------------
module mm_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  mm_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [mm_pkg::ELEM_W-1:0]  a_data,
  input  logic signed [mm_pkg::ELEM_W-1:0]  b_data,
  output logic signed [mm_pkg::SUM_W-1:0]   acc,
  output logic                              busy
);

  logic signed [mm_pkg::PROD_W-1:0] prod;
  logic                             prod_vld;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.operand_valid;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + mm_pkg::SUM_W'(prod);
    end
  end

  assign busy = prod_vld;

endmodule

[rtl/core/matrix_multiply.sv]
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point general matrix multiply, C = A x B
// Loads A then B one Q8.8 element per transfer, then walks every element
// of C through one shared multiply-accumulate unit and emits the Q19.16 sums.
//
//   port    dir   payload                                        role
//   cfg     in    index, data                                    dimension writes
//   feed    in    element                                        A then B, row-major
//   result  out   product_value, row_index, col_index, last_result  C, row-major
//
// Loading takes one element per feed transfer; feed is ready only while loading and
// no register write is offered on cfg.
// Each element of C issues one store read per k in S_MAC, drains the read
// and multiply stages in S_DRAIN, then emits in S_EMIT; the pace is set by the
// single multiplier and the single read port of each store.
// Synchronous active-high reset; dimensions reset to 8, no clearing pass.
// A stall on result holds the sequencer in its emit step until the
// output register frees up.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  mm_cfg_if.sink            cfg,
  mm_feed_if.sink           feed,
  mm_result_if.source       result
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int IW    = (DW > mm_pkg::IDX_W) ? DW : mm_pkg::IDX_W;
  localparam int LW    = $clog2(2 * DEPTH + 1);

  typedef enum logic [1:0] {S_LOAD, S_MAC, S_DRAIN, S_EMIT} state_t;

  // Configuration registers
  logic [mm_pkg::CFG_DATA_W-1:0] rows_a;
  logic [mm_pkg::CFG_DATA_W-1:0] inner_dim;
  logic [mm_pkg::CFG_DATA_W-1:0] cols_b;

  // Effective dimensions
  logic [IW-1:0] nr, nk, nc;
  logic [LW-1:0] size_a, size_total;

  // Sequencer
  state_t        state;
  logic [LW-1:0] load_count;
  logic [IW-1:0] row, col, kk;
  logic [AW-1:0] a_base, a_addr, b_addr;
  logic          rd_vld;

  // Stores and read data
  logic signed [mm_pkg::ELEM_W-1:0] left_store  [DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] right_store [DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] a_q, b_q;

  // MAC unit link
  mm_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [mm_pkg::SUM_W-1:0]  acc;
  logic                             mac_busy;

  logic feed_xfer, cfg_xfer, load_last, last_k, last_col, last_row, emit_go;

  // Clamp a dimension register into 1..MAX_DIM
  function automatic logic [IW-1:0] clamp_dim(input logic [mm_pkg::CFG_DATA_W-1:0] v);
    logic [IW-1:0] r;
    if (v == '0) begin
      r = IW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = IW'(MAX_DIM);
    end else begin
      r = IW'(v);
    end
    return r;
  endfunction

  always_comb begin
    nr         = clamp_dim(rows_a);
    nk         = clamp_dim(inner_dim);
    nc         = clamp_dim(cols_b);
    size_a     = LW'(nr) * LW'(nk);
    size_total = size_a + LW'(nk) * LW'(nc);
  end

  assign cfg.ready  = 1'b1;
  assign feed.ready = (state == S_LOAD) && !cfg.valid;
  assign cfg_xfer   = cfg.valid & cfg.ready;
  assign feed_xfer  = feed.valid & feed.ready;
  assign load_last  = (load_count == size_total - LW'(1));
  assign last_k     = (kk == nk - IW'(1));
  assign last_col   = (col == nc - IW'(1));
  assign last_row   = (row == nr - IW'(1));
  assign emit_go    = (state == S_EMIT) && (!result.valid || result.ready);

  // Write the dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= mm_pkg::DIM_RESET;
      inner_dim <= mm_pkg::DIM_RESET;
      cols_b    <= mm_pkg::DIM_RESET;
    end else if (cfg_xfer) begin
      case (cfg.index)
        mm_pkg::REG_ROWS_A:    rows_a    <= cfg.data;
        mm_pkg::REG_INNER_DIM: inner_dim <= cfg.data;
        mm_pkg::REG_COLS_B:    cols_b    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Store A: write on load, registered read for the MAC
  always_ff @(posedge clk) begin
    if (feed_xfer && load_count < size_a) begin
      left_store[load_count[AW-1:0]] <= feed.element;
    end
    a_q <= left_store[a_addr];
  end

  // Store B: write on load, registered read for the MAC
  always_ff @(posedge clk) begin
    if (feed_xfer && load_count >= size_a) begin
      right_store[AW'(load_count - size_a)] <= feed.element;
    end
    b_q <= right_store[b_addr];
  end

  // Drive the MAC unit
  always_comb begin
    mac_ctrl.operand_valid = rd_vld;
    mac_ctrl.clear         = (state == S_LOAD) || emit_go;
  end

  mm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_data (a_q),
    .b_data (b_q),
    .acc    (acc),
    .busy   (mac_busy)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      load_count   <= '0;
      rd_vld       <= 1'b0;
      result.valid <= 1'b0;
      row          <= '0;
      col          <= '0;
      kk           <= '0;
      a_base       <= '0;
      a_addr       <= '0;
      b_addr       <= '0;
    end else begin
      rd_vld <= (state == S_MAC);
      if (result.ready && !emit_go) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (cfg_xfer && (cfg.index == mm_pkg::REG_ROWS_A ||
                           cfg.index == mm_pkg::REG_INNER_DIM ||
                           cfg.index == mm_pkg::REG_COLS_B)) begin
            load_count <= '0;
          end else if (feed_xfer) begin
            if (load_last) begin
              load_count <= '0;
              state      <= S_MAC;
              row        <= '0;
              col        <= '0;
              kk         <= '0;
              a_base     <= '0;
              a_addr     <= '0;
              b_addr     <= '0;
            end else begin
              load_count <= load_count + LW'(1);
            end
          end
        end
        S_MAC: begin
          // Issue one k step per cycle
          a_addr <= a_addr + AW'(1);
          b_addr <= AW'(b_addr + AW'(nc));
          kk     <= kk + IW'(1);
          if (last_k) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Wait for the read and multiply stages to empty
          if (!rd_vld && !mac_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            result.valid         <= 1'b1;
            result.product_value <= acc;
            result.row_index     <= row[mm_pkg::IDX_W-1:0];
            result.col_index     <= col[mm_pkg::IDX_W-1:0];
            result.last_result   <= last_row && last_col;
            kk                   <= '0;
            if (last_col && last_row) begin
              state <= S_LOAD;
            end else if (last_col) begin
              state  <= S_MAC;
              col    <= '0;
              row    <= row + IW'(1);
              a_base <= AW'(a_base + AW'(nk));
              a_addr <= AW'(a_base + AW'(nk));
              b_addr <= '0;
            end else begin
              state  <= S_MAC;
              col    <= col + IW'(1);
              a_addr <= a_base;
              b_addr <= AW'(col + IW'(1));
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

[tb/sv/mm_product_check.sv]
// ----------------------------------------------------------------------------
// mm_product_check: product prediction and comparison for matrix_multiply
// Watches the cfg, feed and result channels. It tracks the dimension
// registers and both element stores, and it computes every element of C when
// the last element of B is taken. It then compares each result transfer
// field by field with the oldest predicted element.
// ----------------------------------------------------------------------------
module mm_product_check #(
  parameter int MAX_DIM = 8
) (
  input  logic   clk,
  input  logic   rst,
  mm_cfg_if      cfg,
  mm_feed_if     feed,
  mm_result_if   result,
  output int     failures,
  output int     outstanding
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

  typedef struct {
    logic signed [mm_pkg::SUM_W-1:0] value;
    logic [mm_pkg::IDX_W-1:0]        row;
    logic [mm_pkg::IDX_W-1:0]        col;
    logic                            last;
  } product_t;

  logic [mm_pkg::CFG_DATA_W-1:0]    rows_reg;
  logic [mm_pkg::CFG_DATA_W-1:0]    inner_reg;
  logic [mm_pkg::CFG_DATA_W-1:0]    cols_reg;
  logic signed [mm_pkg::ELEM_W-1:0] a_store [STORE_DEPTH];
  logic signed [mm_pkg::ELEM_W-1:0] b_store [STORE_DEPTH];
  int                               loaded;
  int                               fail_count;
  product_t                         expected_products [$];
  product_t                         oldest;

  // Out-of-range dimensions act as the nearest legal size
  function automatic int dim_of(input logic [mm_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    fail_count++;
  endtask

  // Compute every element of C from the stores, row-major
  task automatic queue_products();
    int       nr;
    int       nk;
    int       nc;
    longint   acc;
    product_t p;
    nr = dim_of(rows_reg);
    nk = dim_of(inner_reg);
    nc = dim_of(cols_reg);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'(a_store[i * nk + k]) * longint'(b_store[k * nc + j]);
        end
        p.value = acc[mm_pkg::SUM_W-1:0];
        p.row   = mm_pkg::IDX_W'(i);
        p.col   = mm_pkg::IDX_W'(j);
        p.last  = (i == nr - 1) && (j == nc - 1);
        expected_products.push_back(p);
      end
    end
  endtask

  // Load one element into A or B; fire the product on the last one of B
  task automatic take_element(input logic signed [mm_pkg::ELEM_W-1:0] e);
    int size_a;
    int size_b;
    size_a = dim_of(rows_reg) * dim_of(inner_reg);
    size_b = dim_of(inner_reg) * dim_of(cols_reg);
    if (loaded < size_a) begin
      a_store[loaded] = e;
    end else begin
      b_store[loaded - size_a] = e;
    end
    loaded++;
    if (loaded >= size_a + size_b) begin
      loaded = 0;
      queue_products();
    end
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_result();
    if (expected_products.size() == 0) begin
      report_mismatch($sformatf("unexpected product at (%0d,%0d) value %0d",
                                result.row_index, result.col_index,
                                result.product_value));
      return;
    end
    oldest = expected_products.pop_front();
    if (result.product_value !== oldest.value) begin
      report_mismatch($sformatf("product (%0d,%0d): value %0d, want %0d",
                                oldest.row, oldest.col, result.product_value,
                                oldest.value));
    end
    if (result.row_index !== oldest.row) begin
      report_mismatch($sformatf("product (%0d,%0d): row_index %0d",
                                oldest.row, oldest.col, result.row_index));
    end
    if (result.col_index !== oldest.col) begin
      report_mismatch($sformatf("product (%0d,%0d): col_index %0d",
                                oldest.row, oldest.col, result.col_index));
    end
    if (result.last_result !== oldest.last) begin
      report_mismatch($sformatf("product (%0d,%0d): last_result %0b, want %0b",
                                oldest.row, oldest.col, result.last_result,
                                oldest.last));
    end
  endtask

  // Track every transfer on the three channels
  always @(posedge clk) begin
    if (rst) begin
      rows_reg   = mm_pkg::DIM_RESET;
      inner_reg  = mm_pkg::DIM_RESET;
      cols_reg   = mm_pkg::DIM_RESET;
      loaded     = 0;
      fail_count = 0;
      expected_products.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mm_pkg::REG_ROWS_A: begin
            rows_reg = cfg.data;
            loaded   = 0;
          end
          mm_pkg::REG_INNER_DIM: begin
            inner_reg = cfg.data;
            loaded    = 0;
          end
          mm_pkg::REG_COLS_B: begin
            cols_reg = cfg.data;
            loaded   = 0;
          end
          default: begin
          end
        endcase
      end
      if (feed.valid && feed.ready) begin
        take_element(feed.element);
      end
      if (result.valid && result.ready) begin
        check_result();
      end
    end
    failures    <= fail_count;
    outstanding <= expected_products.size();
  end

endmodule

[tb/sv/matrix_multiply_tb.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_tb: stimulus and verdict for matrix_multiply
// Drives dimension writes and matrix elements: a directed opening on extreme
// values, clamped sizes and aborted loads, then random runs in three idling
// phases. The product checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;

  localparam int MAX_DIM       = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [mm_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  int   feed_idle_pct = 0;
  int   result_idle_pct = 0;

  logic [mm_pkg::CFG_DATA_W-1:0] cur_rows;
  logic [mm_pkg::CFG_DATA_W-1:0] cur_inner;
  logic [mm_pkg::CFG_DATA_W-1:0] cur_cols;

  mm_cfg_if    cfg_ch ();
  mm_feed_if   feed_ch ();
  mm_result_if result_ch ();

  matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .feed   (feed_ch),
    .result (result_ch)
  );

  mm_product_check #(.MAX_DIM(MAX_DIM)) product_check_i (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .feed        (feed_ch),
    .result      (result_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("matrix_multiply test failed");
    $finish;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= result_idle_pct);
    end
  end

  function automatic int effective_dim(input logic [mm_pkg::CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Mostly small sizes; now and then zero or a value from 8 to 15
  function automatic logic [mm_pkg::CFG_DATA_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 10) return mm_pkg::CFG_DATA_W'($urandom_range(15, 8));
    return mm_pkg::CFG_DATA_W'($urandom_range(4, 1));
  endfunction

  function automatic logic signed [mm_pkg::ELEM_W-1:0] random_element();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return mm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Drop feed valid, wait for all products, then let the pipeline settle
  task automatic wait_idle();
    feed_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold one register write until its transfer; caller drops valid
  task automatic write_reg(input logic [mm_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [mm_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_dims(input logic [mm_pkg::CFG_DATA_W-1:0] r,
                          input logic [mm_pkg::CFG_DATA_W-1:0] k,
                          input logic [mm_pkg::CFG_DATA_W-1:0] c);
    wait_idle();
    write_reg(mm_pkg::REG_ROWS_A, r);
    write_reg(mm_pkg::REG_INNER_DIM, k);
    write_reg(mm_pkg::REG_COLS_B, c);
    cfg_ch.valid <= 1'b0;
    cur_rows  = r;
    cur_inner = k;
    cur_cols  = c;
  endtask

  // Idle at random, then hold the element until its transfer
  task automatic send_element(input logic signed [mm_pkg::ELEM_W-1:0] e);
    while ($urandom_range(99) < feed_idle_pct) begin
      feed_ch.valid <= 1'b0;
      @(posedge clk);
    end
    feed_ch.valid   <= 1'b1;
    feed_ch.element <= e;
    do @(posedge clk); while (!feed_ch.ready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_element(random_element());
    end
  endtask

  // Random runs: mostly complete loads, some cut short by a register write
  task automatic run_phase(input int src_pct, input int sink_pct, input int quota);
    int sent;
    int total;
    int cut;
    bit need_cfg;
    feed_idle_pct   = src_pct;
    result_idle_pct = sink_pct;
    sent     = 0;
    need_cfg = 1'b1;
    while (sent < quota) begin
      if (need_cfg || $urandom_range(99) < 70) begin
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end else if ($urandom_range(1) == 0) begin
        wait_idle();
      end
      need_cfg = 1'b0;
      total = effective_dim(cur_rows) * effective_dim(cur_inner)
            + effective_dim(cur_inner) * effective_dim(cur_cols);
      if ($urandom_range(99) < 12) begin
        cut = $urandom_range(total - 1, 1);
        send_random(cut);
        sent += cut;
        need_cfg = 1'b1;
      end else begin
        send_random(total);
        sent += total;
      end
    end
  endtask

  initial begin
    feed_ch.valid   <= 1'b0;
    feed_ch.element <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-element products on the extreme values
    set_dims(4'd1, 4'd1, 4'd1);
    send_element(16'sh8000);
    send_element(16'sh8000);
    send_element(16'sh7fff);
    send_element(16'sh8000);

    // Zero dimensions act as one
    set_dims(4'd0, 4'd0, 4'd0);
    send_element(16'sh7fff);
    send_element(16'sh7fff);

    // A write to the spare index must not disturb a load in progress
    send_element(16'sh0100);
    wait_idle();
    write_reg(REG_SPARE, 4'd5);
    cfg_ch.valid <= 1'b0;
    send_element(16'shff00);

    // Abort a partial load with a register write, then load again from A
    set_dims(4'd1, 4'd2, 4'd1);
    send_element(16'sh1234);
    set_dims(4'd2, 4'd2, 4'd1);
    send_element(16'sh8000);
    send_element(16'sh7fff);
    send_element(16'shffff);
    send_element(16'sh0001);
    send_element(16'sh8000);
    send_element(16'sh8000);

    // Oversized column count clamps to the maximum
    set_dims(4'd1, 4'd1, 4'd15);
    for (int n = 0; n < 9; n++) begin
      send_element(16'sh8000);
    end

    run_phase(13, 80, 90);
    run_phase(80, 13, 90);
    run_phase(0, 0, 90);

    wait_idle();
    if (failures == 0 && outstanding == 0) begin
      $display("matrix_multiply test passed");
    end else begin
      $display("matrix_multiply test failed");
    end
    $finish;
  end

endmodule
